FILE: rtl/core/pwq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pwq_pkg;

	localparam int QUEUE_DEPTH    = 16;
	localparam int RESOURCE_KINDS = 4;
	localparam int ID_BITS        = 8;

	localparam int NEED_W = 4;
	localparam int NEEDS_W = NEED_W * RESOURCE_KINDS;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int OP_W   = 3;
	localparam int PID_W  = 8;
	localparam int RIDX_W = 2;
	localparam int STAT_W = 2;
	localparam int RID_W  = 8;
	localparam int OCC_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_FIT    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic                valid;
		logic [ID_BITS-1:0]  id;
		logic [NEEDS_W-1:0]  needs;
	} entry_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic                push;
		logic                take;
		logic [OP_W-1:0]     op;
		logic [ID_BITS-1:0]  pid;
		logic [RIDX_W-1:0]   ridx;
		logic [NEED_W-1:0]   avail;
		logic [NEEDS_W-1:0]  needs;
	} cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/process_wait_queue.sv
// Each accepted input beat has its result beat registered on m_tdata in the next cycle.
// Throughput: one operation per cycle; every cell compares and shifts in the same
// cycle, and the next beat is taken as soon as the output register is free or drained.
// Reset: arst_n clears the cell valid bits, the entry count and the output valid flag;
// entry payload and output data are not reset.
`timescale 1ns / 1ps
`default_nettype none
module process_wait_queue
	import pwq_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// operation[2:0], process_id[10:3], resource_index[12:11], available_units[16:13],
	// need_zero[20:17], need_one[24:21], need_two[28:25], need_three[32:29], zero pad
	input  wire  [39:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// status[1:0], result_id[9:2], occupancy[14:10], zero pad
	output logic [15:0] m_tdata
);

	logic [OP_W-1:0]    op;
	logic [PID_W-1:0]   pid_in;
	logic [RIDX_W-1:0]  ridx;
	logic [NEED_W-1:0]  avail;
	logic [4*NEED_W-1:0] needs_all;
	logic               accept;
	logic               full;
	logic               is_take;
	cmd_t               cmd;

	entry_t             cells [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] hit_chain;
	logic [ID_BITS-1:0] rid_chain [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH-1:0] valid_vec;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nx;
	logic [STAT_W-1:0]  status_nx;
	logic [ID_BITS-1:0] rid_nx;

	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [RID_W-1:0]   rid_q;
	logic [OCC_W-1:0]   occ_q;

	assign op        = s_tdata[2:0];
	assign pid_in    = s_tdata[10:3];
	assign ridx      = s_tdata[12:11];
	assign avail     = s_tdata[16:13];
	assign needs_all = s_tdata[32:17];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_take  = (op == OP_POP) || (op == OP_REMOVE) || (op == OP_FIT);

	assign cmd.push  = accept && (op == OP_PUSH) && !full;
	assign cmd.take  = accept && is_take;
	assign cmd.op    = op;
	assign cmd.pid   = pid_in[ID_BITS-1:0];
	assign cmd.ridx  = ridx;
	assign cmd.avail = avail;
	assign cmd.needs = needs_all[NEEDS_W-1:0];

	assign hit_chain[0] = 1'b0;
	assign rid_chain[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   prev_v;
		entry_t nbr;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cells[i-1].valid;
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cells[i+1];
		end

		pwq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (prev_v),
			.next       (nbr),
			.hit_in     (hit_chain[i]),
			.rid_in     (rid_chain[i]),
			.hit_out    (hit_chain[i+1]),
			.rid_out    (rid_chain[i+1]),
			.cur        (cells[i])
		);

		assign valid_vec[i] = cells[i].valid;
	end

	always_comb begin
		status_nx = ST_MISS;
		rid_nx    = '0;
		count_nx  = count_q;
		unique case (op)
			OP_PUSH: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					status_nx = ST_OK;
					count_nx  = count_q + 1'b1;
				end
			end
			OP_POP, OP_REMOVE, OP_FIT: begin
				if (hit_chain[QUEUE_DEPTH]) begin
					status_nx = ST_OK;
					rid_nx    = rid_chain[QUEUE_DEPTH];
					count_nx  = count_q - 1'b1;
				end
			end
			OP_PEEK: begin
				if (hit_chain[QUEUE_DEPTH]) begin
					status_nx = ST_OK;
					rid_nx    = rid_chain[QUEUE_DEPTH];
				end
			end
			default: begin
				status_nx = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nx;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nx;
			rid_q    <= RID_W'(rid_nx);
			occ_q    <= OCC_W'(count_nx);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, occ_q, rid_q, status_q};

`ifndef ASSERT_OFF
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("entry count does not match valid cells");

	a_cells_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid cells are not packed at the head");

	a_miss_has_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_OK) |-> rid_q == '0)
		else $error("result id nonzero on a miss");

	a_take_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && hit_chain[QUEUE_DEPTH] |=> count_q == $past(count_q) - 1'b1)
		else $error("taken entry did not shrink the queue");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/pwq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pwq_cell
	import pwq_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  cmd_t               cmd,
	input  wire                prev_valid,
	input  entry_t             next,
	input  wire                hit_in,
	input  wire  [ID_BITS-1:0] rid_in,
	output logic               hit_out,
	output logic [ID_BITS-1:0] rid_out,
	output entry_t             cur
);

	logic               valid_q;
	logic [ID_BITS-1:0] id_q;
	logic [NEEDS_W-1:0] needs_q;
	logic [NEED_W-1:0]  sel_need;
	logic               match;
	logic               first;
	logic               shift;
	logic               load;

	always_comb begin
		sel_need = '0;
		for (int k = 0; k < RESOURCE_KINDS; k++) begin
			if (int'(cmd.ridx) == k)
				sel_need = needs_q[k*NEED_W +: NEED_W];
		end
	end

	// valid entries are contiguous from the head, so the first valid cell is the head
	always_comb begin
		unique case (cmd.op)
			OP_POP, OP_PEEK: match = valid_q;
			OP_REMOVE:       match = valid_q && (id_q == cmd.pid);
			OP_FIT:          match = valid_q && (int'(cmd.ridx) < RESOURCE_KINDS)
			                         && (sel_need <= cmd.avail);
			default:         match = 1'b0;
		endcase
	end

	assign first   = match && !hit_in;
	assign hit_out = hit_in || match;
	assign rid_out = first ? id_q : rid_in;

	// close the gap: every cell at or behind the taken one pulls from its neighbor
	assign shift = cmd.take && hit_out;
	assign load  = cmd.push && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next.valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q    <= next.id;
			needs_q <= next.needs;
		end else if (load) begin
			id_q    <= cmd.pid;
			needs_q <= cmd.needs;
		end
	end

	assign cur.valid = valid_q;
	assign cur.id    = id_q;
	assign cur.needs = needs_q;

endmodule
`default_nettype wire

FILE: tb/wait_queue_checker.sv
`timescale 1ns / 1ps
module wait_queue_checker
	import pwq_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	// operation[2:0], process_id[10:3], resource_index[12:11], available_units[16:13],
	// need_zero[20:17], need_one[24:21], need_two[28:25], need_three[32:29], zero pad
	input  wire  [39:0] s_tdata,
	input  wire         m_tvalid,
	input  wire         m_tready,
	// status[1:0], result_id[9:2], occupancy[14:10], zero pad
	input  wire  [15:0] m_tdata,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [RID_W-1:0]  result_id;
		logic [OCC_W-1:0]  occupancy;
	} queue_reply_t;

	// shadow copy of the queue, head at index 0
	logic [ID_BITS-1:0] shadow_ids[$];
	logic [NEEDS_W-1:0] shadow_needs[$];
	queue_reply_t       replies_due[$];
	int                 fail_count = 0;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic queue_reply_t apply_operation(input logic [39:0] beat);
		logic [OP_W-1:0]    op;
		logic [ID_BITS-1:0] pid;
		logic [RIDX_W-1:0]  ridx;
		logic [NEED_W-1:0]  avail;
		logic [NEEDS_W-1:0] needs;
		queue_reply_t       r;
		int                 i;
		int                 hit;
		op    = beat[2:0];
		pid   = beat[3 +: ID_BITS];
		ridx  = beat[12:11];
		avail = beat[16:13];
		needs = beat[17 +: NEEDS_W];
		r.status = ST_MISS;
		r.result_id = '0;
		hit = -1;
		case (op)
			OP_PUSH: begin
				if (shadow_ids.size() >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_ids.push_back(pid);
					shadow_needs.push_back(needs);
					r.status = ST_OK;
				end
			end
			OP_POP, OP_PEEK: begin
				if (shadow_ids.size() > 0) begin
					r.result_id = shadow_ids[0];
					r.status = ST_OK;
					if (op == OP_POP) hit = 0;
				end
			end
			OP_REMOVE: begin
				for (i = 0; i < shadow_ids.size() && hit < 0; i++)
					if (shadow_ids[i] == pid) hit = i;
			end
			OP_FIT: begin
				if (ridx < RESOURCE_KINDS)
					for (i = 0; i < shadow_ids.size() && hit < 0; i++)
						if (shadow_needs[i][NEED_W*ridx +: NEED_W] <= avail) hit = i;
			end
			default: ;
		endcase
		// close up behind the taken entry
		if (hit >= 0) begin
			r.result_id = shadow_ids[hit];
			r.status = ST_OK;
			shadow_ids.delete(hit);
			shadow_needs.delete(hit);
		end
		r.occupancy = OCC_W'(shadow_ids.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_reply_t want;
		queue_reply_t got;
		if (!arst_n) begin
			shadow_ids.delete();
			shadow_needs.delete();
			replies_due.delete();
			pending <= 0;
		end else begin
			// the reply leaving now belongs to an earlier beat, so check before predicting
			if (m_tvalid && m_tready) begin
				got = {m_tdata[1:0], m_tdata[9:2], m_tdata[14:10]};
				if (replies_due.size() == 0) begin
					$error("result beat with no operation outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.result_id !== want.result_id) begin
						$error("result_id: expected %0d, got %0d", want.result_id,
							got.result_id);
						fail_count++;
					end
					if (got.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d", want.occupancy,
							got.occupancy);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(apply_operation(s_tdata));
			pending <= replies_due.size();
		end
		errors <= fail_count;
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import pwq_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
	localparam int RANDOM_OPS = 950;
	localparam int RUN_LIMIT  = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          send_calm = 0;
	int          drain_calm = 0;
	logic [7:0]  id_pool[16];
	int          pool_wr = 0;

	always #5 clk = ~clk;

	process_wait_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	wait_queue_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// mostly random gaps, now and then a stretch with none
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	function automatic logic [39:0] op_beat(input logic [OP_W-1:0] op, input logic [7:0] pid,
			input logic [1:0] ridx, input logic [3:0] avail, input logic [15:0] needs);
		logic [39:0] beat;
		beat = '0;
		beat[2:0]   = op;
		beat[10:3]  = pid;
		beat[12:11] = ridx;
		beat[16:13] = avail;
		beat[32:17] = needs;
		return beat;
	endfunction

	task automatic send_op(input logic [39:0] beat);
		int gap;
		gap = draw_gap(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= beat;
		if (beat[2:0] == OP_PUSH) begin
			id_pool[pool_wr] = beat[10:3];
			pool_wr = (pool_wr + 1) % 16;
		end
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random_op(input int mode);
		int          pick;
		logic [7:0]  pid;
		logic [15:0] needs;
		pick = $urandom_range(0, 99);
		pid = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
		needs = 16'($urandom);
		// fill, drain and mixed phases shift the weight between pushes and removals
		if (mode == 0) pick = (pick < 65) ? 0 : pick;
		else if (mode == 1) pick = (pick < 15) ? 0 : (pick < 35) ? 70 : pick;
		else pick = (pick < 35) ? 0 : pick;
		if (pick == 0)
			send_op(op_beat(OP_PUSH, pid, 2'($urandom), 4'($urandom), needs));
		else if (pick < 72)
			send_op(op_beat(OP_POP, pid, 2'($urandom), 4'($urandom), needs));
		else if (pick < 80)
			send_op(op_beat(OP_PEEK, pid, 2'($urandom), 4'($urandom), needs));
		else if (pick < 89)
			send_op(op_beat(OP_REMOVE, $urandom_range(0, 4) != 0 ?
				id_pool[$urandom_range(0, 15)] : pid, 2'($urandom), 4'($urandom), needs));
		else if (pick < 97)
			send_op(op_beat(OP_FIT, pid, 2'($urandom), 4'($urandom), needs));
		else
			send_op(op_beat(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pid,
				2'($urandom), 4'($urandom), needs));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("process_wait_queue: mismatch");
			$finish;
		end
	end

	// result side: a random stall, which may be zero, before each beat
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = draw_gap(drain_calm);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int k;
		int sent;
		int mode;
		int phase_left;
		for (k = 0; k < 16; k++) id_pool[k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// operations on an empty queue and an unused code
		send_op(op_beat(OP_POP, 8'd0, 2'd0, 4'd0, 16'h0000));
		send_op(op_beat(OP_PEEK, 8'd0, 2'd0, 4'd0, 16'h0000));
		send_op(op_beat(OP_REMOVE, 8'd0, 2'd0, 4'd0, 16'h0000));
		send_op(op_beat(OP_FIT, 8'd0, 2'd0, 4'd15, 16'h0000));
		send_op(op_beat(OP_SPARE_LAST, 8'hff, 2'd3, 4'd15, 16'hffff));
		// fill to the brim; only entry 9 asks for none of resource 3
		for (k = 0; k < 16; k++)
			send_op(op_beat(OP_PUSH, (k == 0) ? 8'd0 : (k == 15) ? 8'd255 : 8'(k * 16 + 1),
				2'd0, 4'd0, {(k == 9) ? 4'd0 : 4'd15, k[0] ? 4'd15 : 4'd0, 4'(k),
				4'(15 - k)}));
		send_op(op_beat(OP_PUSH, 8'haa, 2'd1, 4'd5, 16'h5555));
		send_op(op_beat(OP_REMOVE, 8'd113, 2'd0, 4'd0, 16'h0000));
		send_op(op_beat(OP_REMOVE, 8'd200, 2'd0, 4'd0, 16'h0000));
		send_op(op_beat(OP_FIT, 8'd0, 2'd3, 4'd0, 16'h0000));
		send_op(op_beat(OP_FIT, 8'd0, 2'd3, 4'd0, 16'h0000));
		send_op(op_beat(OP_FIT, 8'd0, 2'd0, 4'd0, 16'h0000));
		send_op(op_beat(OP_PEEK, 8'd0, 2'd0, 4'd0, 16'h0000));
		send_op(op_beat(OP_POP, 8'd0, 2'd0, 4'd0, 16'h0000));

		sent = 0;
		mode = 0;
		phase_left = 0;
		while (sent < RANDOM_OPS) begin
			if (phase_left == 0) begin
				mode = $urandom_range(0, 2);
				phase_left = $urandom_range(10, 40);
			end
			send_random_op(mode);
			phase_left--;
			sent++;
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("process_wait_queue: match");
		else
			$display("process_wait_queue: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/pwq_pkg.sv
rtl/core/pwq_cell.sv
rtl/core/process_wait_queue.sv
tb/wait_queue_checker.sv
tb/tb.sv
